### design/ole_pkg.sv
`default_nettype none

package ole_pkg;

   // default sizing
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   // fixed field widths of the channels
   localparam int OPCODE_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 5;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 4;
   localparam int COUNT_W    = 5;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PREPEND = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_FIND    = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  removed_value;
      logic [INDEX_W-1:0]  found_index;
      logic [COUNT_W-1:0]  count;
   } ole_rsp_type;

endpackage

`default_nettype wire

### design/ordered_list_engine.sv
// Sequence: clear, no-ops, refusals and find on an empty list go straight to done; find compares
//   words from index 0 to a match or the end, remove moves each word past the position down one,
//   and insert moves the words from the position on up, top first, then writes the new word.
// Flow: one item in flight; the list memory does one read and one write per cycle, and the next
//   item is taken as the result of the last one enters the output register.
// Reset: synchronous, active high; empties the list and drops any pending result, store kept.
`default_nettype none

module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic        [OPCODE_W-1:0]   req_opcode,
   input  wire logic signed [VALUE_W-1:0]    req_value,
   input  wire logic        [POSITION_W-1:0] req_position,

   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic             [STATUS_W-1:0]   rsp_status,
   output logic signed      [VALUE_W-1:0]    rsp_removed_value,
   output logic             [INDEX_W-1:0]    rsp_found_index,
   output logic             [COUNT_W-1:0]    rsp_count
);

   // Sign-extend (or truncate) the incoming word to the stored width.
   logic [DATA_WIDTH-1:0] req_word;
   assign req_word = DATA_WIDTH'(req_value);

   logic        seq_idle, seq_done, res_ready;
   ole_rsp_type seq_res;

   // Output register: a result may sit here while the next item starts.
   logic        rsp_valid_ff, rsp_valid_in;
   ole_rsp_type rsp_data_ff;

   // Hand the result over when the output register is empty or draining.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   ole_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid),
      .opcode    (req_opcode),
      .word      (req_word),
      .position  (req_position),
      .idle      (seq_idle),
      .done      (seq_done),
      .res_ready (res_ready),
      .res       (seq_res)
   );

   // The sequencer takes an item only from its idle state.
   assign req_ready = seq_idle;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_done && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the payload on hand-off; hold otherwise.
   always_ff @(posedge clock) begin
      if (seq_done && res_ready) begin
         rsp_data_ff <= seq_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_removed_value = rsp_data_ff.removed_value;
   assign rsp_found_index   = rsp_data_ff.found_index;
   assign rsp_count         = rsp_data_ff.count;

endmodule

`default_nettype wire

### design/ole_mem.sv
`default_nettype none

module ole_mem
   import ole_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int WIDTH = DEF_DATA_WIDTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ole_seq.sv
`default_nettype none

module ole_seq
   import ole_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [OPCODE_W-1:0]   opcode,
   input  wire logic [DATA_WIDTH-1:0] word,
   input  wire logic [POSITION_W-1:0] position,
   output logic                       idle,
   output logic                       done,
   input  wire logic                  res_ready,
   output ole_rsp_type                res
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_FILL = 4'b0100,
      S_DONE = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [VALUE_W-1:0]    removed_ff, removed_in;
   logic [INDEX_W-1:0]    found_ff, found_in;

   logic                  mem_we, mem_re;
   logic [CW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   logic [PW-1:0] ins_pos, req_pos, cnt_wide;
   logic [CW-1:0] last_addr;

   assign cnt_wide  = PW'(cnt_ff);
   assign req_pos   = PW'(position);
   assign last_addr = cnt_ff - CW'(1);

   always_comb begin
      case (opcode)
         OP_APPEND:  ins_pos = cnt_wide;
         OP_PREPEND: ins_pos = '0;
         default:    ins_pos = req_pos;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      word_in    = word_ff;
      pos_in     = pos_ff;
      addr_in    = addr_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = mem_rdata;
      mem_re     = 1'b0;
      mem_raddr  = addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = opcode;
               word_in    = word;
               status_in  = ST_OK;
               removed_in = '0;
               found_in   = '0;
               state_in   = S_DONE;
               case (opcode)
                  OP_APPEND, OP_PREPEND, OP_INSERT: begin
                     if (ins_pos > cnt_wide) begin
                        status_in = ST_BADPOS;
                     end else if (cnt_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in = CW'(ins_pos);
                        if (ins_pos == cnt_wide) begin
                           state_in = S_FILL;
                        end else begin
                           // move words up, starting from the top
                           mem_re    = 1'b1;
                           mem_raddr = last_addr;
                           addr_in   = last_addr;
                           state_in  = S_RUN;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (req_pos >= cnt_wide) begin
                        status_in  = ST_BADPOS;
                        removed_in = '1;
                     end else begin
                        pos_in    = CW'(req_pos);
                        mem_re    = 1'b1;
                        mem_raddr = CW'(req_pos);
                        addr_in   = CW'(req_pos);
                        state_in  = S_RUN;
                     end
                  end
                  OP_FIND: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        addr_in   = '0;
                        state_in  = S_RUN;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         S_RUN: begin
            case (op_ff)
               OP_REMOVE: begin
                  if (addr_ff == pos_ff) begin
                     removed_in = VALUE_W'(mem_rdata);
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = addr_ff - CW'(1);
                  end
                  if (addr_ff == last_addr) begin
                     cnt_in   = last_addr;
                     state_in = S_DONE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = addr_ff + CW'(1);
                     addr_in   = addr_ff + CW'(1);
                  end
               end
               OP_FIND: begin
                  if (mem_rdata == word_ff) begin
                     found_in = INDEX_W'(addr_ff);
                     state_in = S_DONE;
                  end else if (addr_ff == last_addr) begin
                     status_in = ST_NOTFOUND;
                     state_in  = S_DONE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = addr_ff + CW'(1);
                     addr_in   = addr_ff + CW'(1);
                  end
               end
               default: begin
                  mem_we    = 1'b1;
                  mem_waddr = addr_ff + CW'(1);
                  if (addr_ff == pos_ff) begin
                     state_in = S_FILL;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = addr_ff - CW'(1);
                     addr_in   = addr_ff - CW'(1);
                  end
               end
            endcase
         end

         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = word_ff;
            cnt_in    = cnt_ff + CW'(1);
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      word_ff    <= word_in;
      pos_ff     <= pos_in;
      addr_ff    <= addr_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
   end

   ole_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr[AW-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign idle              = (state_ff == S_IDLE);
   assign done              = (state_ff == S_DONE);
   assign res.status        = status_ff;
   assign res.removed_value = removed_ff;
   assign res.found_index   = found_ff;
   assign res.count         = COUNT_W'(cnt_ff);

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("list count above capacity");

   a_run_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (addr_ff < cnt_ff))
      else $error("scan touches an entry beyond the count");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("insert did not grow the count");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !res_ready) |=> (state_ff == S_DONE && $stable(res)))
      else $error("pending result lost before hand-off");
`endif

endmodule

`default_nettype wire
